@@ hw/rtl/stng_pkg.sv @@
package stng_pkg;

    // Item operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register offsets from the base of the sound unit
    localparam logic [4:0] REG_TRI_LINEAR = 5'h08;
    localparam logic [4:0] REG_TRI_LO     = 5'h0A;
    localparam logic [4:0] REG_TRI_HI     = 5'h0B;
    localparam logic [4:0] REG_NOISE_CTL  = 5'h0C;
    localparam logic [4:0] REG_NOISE_PER  = 5'h0E;
    localparam logic [4:0] REG_NOISE_LEN  = 5'h0F;
    localparam logic [4:0] REG_STATUS     = 5'h15;
    localparam logic [4:0] REG_FRAME      = 5'h17;

    // Register slots within one pulse channel
    localparam logic [1:0] PULSE_CTL      = 2'd0;
    localparam logic [1:0] PULSE_SWEEP    = 2'd1;
    localparam logic [1:0] PULSE_TIMER_LO = 2'd2;
    localparam logic [1:0] PULSE_TIMER_HI = 2'd3;

    localparam logic [15:0] PULSE_MIN_PERIOD = 16'd8;
    localparam logic [15:0] PULSE_MAX_PERIOD = 16'h07FF;
    localparam logic [10:0] TRI_MIN_PERIOD   = 11'd3;
    localparam logic [15:0] QFC_RESET        = 16'd7457;

    // Per-item strobes handed to every channel
    typedef struct packed {
        logic       tick;
        logic       even_tick;
        logic       wr;
        logic [4:0] offset;
        logic [7:0] data;
        logic       quarter;
        logic       half;
    } t_strobe;

    // Frame sequencer events for one item
    typedef struct packed {
        logic quarter;
        logic half;
        logic irq;
    } t_frame_evt;

    // Envelope unit state
    typedef struct packed {
        logic       start;
        logic [3:0] vol;
        logic [3:0] div;
    } t_env;

    function automatic logic [7:0] len_load(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
            5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
            5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
            5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
            5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
            5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
            5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
            5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   default: v = 8'd30;
        endcase
        return v;
    endfunction

    function automatic logic duty_bit(input logic [1:0] mode, input logic [2:0] step);
        logic [7:0] pat;
        case (mode)
            2'd0:    pat = 8'h02;
            2'd1:    pat = 8'h06;
            2'd2:    pat = 8'h1E;
            default: pat = 8'hF9;
        endcase
        return pat[step];
    endfunction

    function automatic logic [11:0] noise_period(input logic [3:0] idx);
        logic [11:0] v;
        case (idx)
            4'd0:  v = 12'd4;    4'd1:  v = 12'd8;    4'd2:  v = 12'd16;   4'd3:  v = 12'd32;
            4'd4:  v = 12'd64;   4'd5:  v = 12'd96;   4'd6:  v = 12'd128;  4'd7:  v = 12'd160;
            4'd8:  v = 12'd202;  4'd9:  v = 12'd254;  4'd10: v = 12'd380;  4'd11: v = 12'd508;
            4'd12: v = 12'd762;  4'd13: v = 12'd1016; 4'd14: v = 12'd2034; default: v = 12'd4068;
        endcase
        return v;
    endfunction

    // One quarter-frame clock of an envelope unit
    function automatic t_env env_clock(input t_env e, input logic [3:0] per, input logic loop);
        t_env r;
        r = e;
        if (e.start) begin
            r.vol   = 4'hF;
            r.div   = per;
            r.start = 1'b0;
        end else if (e.div != 4'd0) begin
            r.div = e.div - 4'd1;
        end else begin
            if (e.vol != 4'd0) begin
                r.vol = e.vol - 4'd1;
            end else if (loop) begin
                r.vol = 4'hF;
            end
            r.div = per;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/square_triangle_noise_sound_generator.sv @@
// Sound generator with two pulse channels, a triangle and a noise channel, driven by a
// stream of beats: a clock tick, a register write or a status read. Every input beat
// yields exactly one output beat with the four channel levels after that beat, the
// status read data and the frame IRQ pulse. One beat is accepted every clock cycle
// unless the input is stalled; it is held in the input register and then applied to
// all channel state, while its result is captured in the output register. The block
// stalls its input only while a result waits in the output register and the output
// side is stalling. The single configuration register sets the number of ticks
// between frame sequencer steps and may be written at any time the block holds
// no beat.
module square_triangle_noise_sound_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_reg_offset,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_pulse_one_level,
    output logic [3:0]  o_pulse_two_level,
    output logic [3:0]  o_triangle_level,
    output logic [3:0]  o_noise_level,
    output logic [3:0]  o_read_data,
    output logic        o_irq_pulse,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic [4:0]  r_in_offset;
    logic [7:0]  r_in_data;
    logic        r_out_valid;
    logic [3:0]  r_p1, r_p2, r_tri, r_noise, r_rd;
    logic        r_irq;
    logic [15:0] r_qfc;
    logic        r_parity;
    logic        in_accept;
    logic        advance;
    logic        is_tick;
    logic        is_wr;
    logic        is_status_rd;
    logic [3:0]  p1_level, p2_level, tri_level, noise_level;
    logic        p1_nz, p2_nz, tri_nz, noise_nz;
    logic [3:0]  n_rd;
    stng_pkg::t_frame_evt frame_evt;
    stng_pkg::t_strobe    strobe;

    // Handshake: a beat moves on whenever the output register is free or emptying
    assign advance     = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign is_tick      = advance && (r_in_op == stng_pkg::OP_TICK);
    assign is_wr        = advance && (r_in_op == stng_pkg::OP_WRITE);
    assign is_status_rd = (r_in_op == stng_pkg::OP_READ) &&
                          (r_in_offset == stng_pkg::REG_STATUS);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op     <= i_operation;
            r_in_offset <= i_reg_offset;
            r_in_data   <= i_write_data;
        end
    end

    // Configuration register and tick parity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qfc    <= stng_pkg::QFC_RESET;
            r_parity <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_qfc <= i_cfg_data;
            end
            if (is_tick) begin
                r_parity <= ~r_parity;
            end
        end
    end

    stng_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (is_tick),
        .i_frame_wr (is_wr && (r_in_offset == stng_pkg::REG_FRAME)),
        .i_data     (r_in_data),
        .i_qfc      (r_qfc),
        .o_evt      (frame_evt)
    );

    // Strobes shared by all channels for the beat being applied
    always_comb begin
        strobe.tick      = is_tick;
        strobe.even_tick = is_tick && r_parity;
        strobe.wr        = is_wr;
        strobe.offset    = r_in_offset;
        strobe.data      = r_in_data;
        strobe.quarter   = frame_evt.quarter;
        strobe.half      = frame_evt.half;
    end

    stng_pulse u_pulse_one (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_channel   (1'b0),
        .i_strobe    (strobe),
        .o_level     (p1_level),
        .o_length_nz (p1_nz)
    );

    stng_pulse u_pulse_two (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_channel   (1'b1),
        .i_strobe    (strobe),
        .o_level     (p2_level),
        .o_length_nz (p2_nz)
    );

    stng_tri u_tri (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_strobe    (strobe),
        .o_level     (tri_level),
        .o_length_nz (tri_nz)
    );

    stng_noise u_noise (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_strobe    (strobe),
        .o_level     (noise_level),
        .o_length_nz (noise_nz)
    );

    assign n_rd = is_status_rd ? {noise_nz, tri_nz, p2_nz, p1_nz} : 4'd0;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_p1    <= p1_level;
            r_p2    <= p2_level;
            r_tri   <= tri_level;
            r_noise <= noise_level;
            r_rd    <= n_rd;
            r_irq   <= frame_evt.irq;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pulse_one_level = r_p1;
    assign o_pulse_two_level = r_p2;
    assign o_triangle_level  = r_tri;
    assign o_noise_level     = r_noise;
    assign o_read_data       = r_rd;
    assign o_irq_pulse       = r_irq;

`ifndef SYNTHESIS
    // The IRQ pulse only ever comes from a tick beat
    a_irq_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_op != stng_pkg::OP_TICK)) |=> !r_irq)
        else $error("IRQ pulse raised by a beat that is not a tick");

    // Read data is zero unless the beat reads the status register
    a_rd_only_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !is_status_rd) |=> (r_rd == 4'd0))
        else $error("read data set by a beat that is not a status read");

    // The input side stalls only while a beat waits in the input register
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked beat");

    // A beat that moves on always leaves a result behind
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("beat applied without a result");
`endif

endmodule

@@ hw/rtl/stng_frame.sv @@
module stng_frame (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tick,
    input  logic                   i_frame_wr,
    input  logic [7:0]             i_data,
    input  logic [15:0]            i_qfc,
    output stng_pkg::t_frame_evt   o_evt
);

    logic        r_five, n_five;
    logic        r_irq_en, n_irq_en;
    logic [2:0]  r_step, n_step;
    logic [15:0] r_count, n_count;
    logic [15:0] count_inc;
    logic [15:0] qfc_eff;
    logic [3:0]  step5;
    logic [2:0]  step4;

    // Interval counter, step counter and mode write
    always_comb begin
        n_five    = r_five;
        n_irq_en  = r_irq_en;
        n_step    = r_step;
        n_count   = r_count;
        o_evt     = '0;
        count_inc = r_count + 16'd1;
        qfc_eff   = (i_qfc == 16'd0) ? 16'd1 : i_qfc;
        step5     = {1'b0, r_step} + 4'd1;
        step4     = r_step + 3'd1;
        if (i_tick) begin
            if (count_inc >= qfc_eff) begin
                n_count = 16'd0;
                if (r_five) begin
                    n_step = (step5 >= 4'd5) ? 3'(step5 - 4'd5) : step5[2:0];
                end else begin
                    n_step = {1'b0, step4[1:0]};
                end
                o_evt.quarter = r_five ? (n_step < 3'd4) : 1'b1;
                o_evt.half    = (n_step == 3'd1) || (n_step == 3'd3);
                o_evt.irq     = !r_five && (n_step == 3'd3) && r_irq_en;
            end else begin
                n_count = count_inc;
            end
        end
        if (i_frame_wr) begin
            n_five   = i_data[7];
            n_irq_en = !i_data[6];
            if (i_data[7]) begin
                o_evt.quarter = 1'b1;
                o_evt.half    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_five   <= 1'b0;
            r_irq_en <= 1'b0;
            r_step   <= 3'd0;
            r_count  <= 16'd0;
        end else begin
            r_five   <= n_five;
            r_irq_en <= n_irq_en;
            r_step   <= n_step;
            r_count  <= n_count;
        end
    end

endmodule

@@ hw/rtl/stng_pulse.sv @@
module stng_pulse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_channel,
    input  stng_pkg::t_strobe  i_strobe,
    output logic [3:0]         o_level,
    output logic               o_length_nz
);

    logic          r_enabled, n_enabled;
    logic [1:0]    r_duty_mode, n_duty_mode;
    logic          r_loop, n_loop;
    logic          r_env_use, n_env_use;
    logic [3:0]    r_env_period, n_env_period;
    stng_pkg::t_env r_env, n_env;
    logic          r_sweep_on, n_sweep_on;
    logic [3:0]    r_sweep_period, n_sweep_period;
    logic          r_sweep_negate, n_sweep_negate;
    logic [2:0]    r_sweep_shift, n_sweep_shift;
    logic          r_sweep_reload, n_sweep_reload;
    logic [3:0]    r_sweep_div, n_sweep_div;
    logic [15:0]   r_timer_period, n_timer_period;
    logic [15:0]   r_timer_count, n_timer_count;
    logic [2:0]    r_duty_step, n_duty_step;
    logic [7:0]    r_length, n_length;
    logic          sel;
    logic          en_bit;
    logic [15:0]   delta;
    logic [15:0]   target;
    logic          audible;

    // Register writes, then the timer, then the frame clocks
    always_comb begin
        n_enabled      = r_enabled;
        n_duty_mode    = r_duty_mode;
        n_loop         = r_loop;
        n_env_use      = r_env_use;
        n_env_period   = r_env_period;
        n_env          = r_env;
        n_sweep_on     = r_sweep_on;
        n_sweep_period = r_sweep_period;
        n_sweep_negate = r_sweep_negate;
        n_sweep_shift  = r_sweep_shift;
        n_sweep_reload = r_sweep_reload;
        n_sweep_div    = r_sweep_div;
        n_timer_period = r_timer_period;
        n_timer_count  = r_timer_count;
        n_duty_step    = r_duty_step;
        n_length       = r_length;
        sel    = i_strobe.wr && (i_strobe.offset[4:3] == 2'b00) &&
                 (i_strobe.offset[2] == i_channel);
        en_bit = i_channel ? i_strobe.data[1] : i_strobe.data[0];

        if (sel) begin
            case (i_strobe.offset[1:0])
                stng_pkg::PULSE_CTL: begin
                    n_duty_mode  = i_strobe.data[7:6];
                    n_loop       = i_strobe.data[5];
                    n_env_use    = !i_strobe.data[4];
                    n_env_period = i_strobe.data[3:0];
                end
                stng_pkg::PULSE_SWEEP: begin
                    n_sweep_on     = i_strobe.data[7];
                    n_sweep_period = {1'b0, i_strobe.data[6:4]} + 4'd1;
                    n_sweep_negate = i_strobe.data[3];
                    n_sweep_shift  = i_strobe.data[2:0];
                    n_sweep_reload = 1'b1;
                end
                stng_pkg::PULSE_TIMER_LO: begin
                    n_timer_period = {r_timer_period[15:8], i_strobe.data};
                end
                default: begin
                    if (r_enabled) begin
                        n_length = stng_pkg::len_load(i_strobe.data[7:3]);
                    end
                    n_timer_period = {5'd0, i_strobe.data[2:0], r_timer_period[7:0]};
                    n_env.start    = 1'b1;
                    n_duty_step    = 3'd0;
                end
            endcase
        end

        if (i_strobe.wr && (i_strobe.offset == stng_pkg::REG_STATUS)) begin
            n_enabled = en_bit;
            if (!en_bit) begin
                n_length = 8'd0;
            end
        end

        if (i_strobe.even_tick) begin
            if (n_timer_count == 16'd0) begin
                n_timer_count = n_timer_period;
                n_duty_step   = n_duty_step + 3'd1;
            end else begin
                n_timer_count = n_timer_count - 16'd1;
            end
        end

        if (i_strobe.quarter) begin
            n_env = stng_pkg::env_clock(n_env, n_env_period, n_loop);
        end

        // Pulse one negates in ones complement, pulse two in twos complement
        delta  = n_timer_period >> n_sweep_shift;
        target = n_sweep_negate ? (n_timer_period - delta - {15'd0, !i_channel})
                                : (n_timer_period + delta);
        if (i_strobe.half) begin
            if (n_sweep_reload) begin
                if (n_sweep_on && (n_sweep_div == 4'd0)) begin
                    n_timer_period = target;
                end
                n_sweep_div    = n_sweep_period;
                n_sweep_reload = 1'b0;
            end else if (n_sweep_div != 4'd0) begin
                n_sweep_div = n_sweep_div - 4'd1;
            end else begin
                if (n_sweep_on) begin
                    n_timer_period = target;
                end
                n_sweep_div = n_sweep_period;
            end
            if (!n_loop && (n_length != 8'd0)) begin
                n_length = n_length - 8'd1;
            end
        end
    end

    // Output level after this item
    always_comb begin
        audible = n_enabled && (n_length != 8'd0) &&
                  stng_pkg::duty_bit(n_duty_mode, n_duty_step) &&
                  (n_timer_period >= stng_pkg::PULSE_MIN_PERIOD) &&
                  (n_timer_period <= stng_pkg::PULSE_MAX_PERIOD);
        o_level     = audible ? (n_env_use ? n_env.vol : n_env_period) : 4'd0;
        o_length_nz = (n_length != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_duty_mode    <= 2'd0;
            r_loop         <= 1'b0;
            r_env_use      <= 1'b0;
            r_env_period   <= 4'd0;
            r_env          <= '0;
            r_sweep_on     <= 1'b0;
            r_sweep_period <= 4'd0;
            r_sweep_negate <= 1'b0;
            r_sweep_shift  <= 3'd0;
            r_sweep_reload <= 1'b0;
            r_sweep_div    <= 4'd0;
            r_timer_period <= 16'd0;
            r_timer_count  <= 16'd0;
            r_duty_step    <= 3'd0;
            r_length       <= 8'd0;
        end else begin
            r_enabled      <= n_enabled;
            r_duty_mode    <= n_duty_mode;
            r_loop         <= n_loop;
            r_env_use      <= n_env_use;
            r_env_period   <= n_env_period;
            r_env          <= n_env;
            r_sweep_on     <= n_sweep_on;
            r_sweep_period <= n_sweep_period;
            r_sweep_negate <= n_sweep_negate;
            r_sweep_shift  <= n_sweep_shift;
            r_sweep_reload <= n_sweep_reload;
            r_sweep_div    <= n_sweep_div;
            r_timer_period <= n_timer_period;
            r_timer_count  <= n_timer_count;
            r_duty_step    <= n_duty_step;
            r_length       <= n_length;
        end
    end

endmodule

@@ hw/rtl/stng_tri.sv @@
module stng_tri (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stng_pkg::t_strobe  i_strobe,
    output logic [3:0]         o_level,
    output logic               o_length_nz
);

    logic        r_enabled, n_enabled;
    logic        r_run, n_run;
    logic [6:0]  r_lin_reload, n_lin_reload;
    logic [6:0]  r_lin, n_lin;
    logic        r_lin_flag, n_lin_flag;
    logic [10:0] r_period, n_period;
    logic [10:0] r_count, n_count;
    logic [4:0]  r_step, n_step;
    logic [7:0]  r_length, n_length;
    logic        wr;
    logic        audible;

    // Register writes, then the timer, then the frame clocks
    always_comb begin
        n_enabled    = r_enabled;
        n_run        = r_run;
        n_lin_reload = r_lin_reload;
        n_lin        = r_lin;
        n_lin_flag   = r_lin_flag;
        n_period     = r_period;
        n_count      = r_count;
        n_step       = r_step;
        n_length     = r_length;
        wr = i_strobe.wr;

        if (wr && (i_strobe.offset == stng_pkg::REG_TRI_LINEAR)) begin
            n_run        = !i_strobe.data[7];
            n_lin_reload = i_strobe.data[6:0];
        end
        if (wr && (i_strobe.offset == stng_pkg::REG_TRI_LO)) begin
            n_period = {r_period[10:8], i_strobe.data};
        end
        if (wr && (i_strobe.offset == stng_pkg::REG_TRI_HI)) begin
            if (r_enabled) begin
                n_length = stng_pkg::len_load(i_strobe.data[7:3]);
            end
            n_period   = {i_strobe.data[2:0], r_period[7:0]};
            n_count    = n_period;
            n_lin_flag = 1'b1;
        end
        if (wr && (i_strobe.offset == stng_pkg::REG_STATUS)) begin
            n_enabled = i_strobe.data[2];
            if (!i_strobe.data[2]) begin
                n_length = 8'd0;
            end
        end

        // The triangle timer runs on every tick
        if (i_strobe.tick) begin
            if (n_count == 11'd0) begin
                n_count = n_period;
                if ((n_length != 8'd0) && (n_lin != 7'd0)) begin
                    n_step = n_step + 5'd1;
                end
            end else begin
                n_count = n_count - 11'd1;
            end
        end

        if (i_strobe.quarter) begin
            if (n_lin_flag) begin
                n_lin = n_lin_reload;
            end else if (n_lin != 7'd0) begin
                n_lin = n_lin - 7'd1;
            end
            if (n_run) begin
                n_lin_flag = 1'b0;
            end
        end
        if (i_strobe.half && n_run && (n_length != 8'd0)) begin
            n_length = n_length - 8'd1;
        end
    end

    // Falling half of the wave first, then the rising half
    always_comb begin
        audible = n_enabled && (n_period >= stng_pkg::TRI_MIN_PERIOD) &&
                  (n_length != 8'd0) && (n_lin != 7'd0);
        o_level     = audible ? (n_step[4] ? n_step[3:0] : ~n_step[3:0]) : 4'd0;
        o_length_nz = (n_length != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b0;
            r_run        <= 1'b0;
            r_lin_reload <= 7'd0;
            r_lin        <= 7'd0;
            r_lin_flag   <= 1'b0;
            r_period     <= 11'd0;
            r_count      <= 11'd0;
            r_step       <= 5'd0;
            r_length     <= 8'd0;
        end else begin
            r_enabled    <= n_enabled;
            r_run        <= n_run;
            r_lin_reload <= n_lin_reload;
            r_lin        <= n_lin;
            r_lin_flag   <= n_lin_flag;
            r_period     <= n_period;
            r_count      <= n_count;
            r_step       <= n_step;
            r_length     <= n_length;
        end
    end

endmodule

@@ hw/rtl/stng_noise.sv @@
module stng_noise (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stng_pkg::t_strobe  i_strobe,
    output logic [3:0]         o_level,
    output logic               o_length_nz
);

    logic           r_enabled, n_enabled;
    logic           r_loop, n_loop;
    logic           r_env_use, n_env_use;
    logic [3:0]     r_env_period, n_env_period;
    stng_pkg::t_env r_env, n_env;
    logic           r_short, n_short;
    logic [11:0]    r_period, n_period;
    logic [11:0]    r_count, n_count;
    logic [14:0]    r_lfsr, n_lfsr;
    logic [7:0]     r_length, n_length;
    logic           wr;
    logic           fb;

    // Register writes, then the timer, then the frame clocks
    always_comb begin
        n_enabled    = r_enabled;
        n_loop       = r_loop;
        n_env_use    = r_env_use;
        n_env_period = r_env_period;
        n_env        = r_env;
        n_short      = r_short;
        n_period     = r_period;
        n_count      = r_count;
        n_lfsr       = r_lfsr;
        n_length     = r_length;
        wr = i_strobe.wr;
        fb = 1'b0;

        if (wr && (i_strobe.offset == stng_pkg::REG_NOISE_CTL)) begin
            n_loop       = i_strobe.data[5];
            n_env_use    = !i_strobe.data[4];
            n_env_period = i_strobe.data[3:0];
            n_env.start  = 1'b1;
        end
        if (wr && (i_strobe.offset == stng_pkg::REG_NOISE_PER)) begin
            n_short  = i_strobe.data[7];
            n_period = stng_pkg::noise_period(i_strobe.data[3:0]);
        end
        if (wr && (i_strobe.offset == stng_pkg::REG_NOISE_LEN)) begin
            if (r_enabled) begin
                n_length = stng_pkg::len_load(i_strobe.data[7:3]);
            end
            n_env.start = 1'b1;
        end
        if (wr && (i_strobe.offset == stng_pkg::REG_STATUS)) begin
            n_enabled = i_strobe.data[3];
            if (!i_strobe.data[3]) begin
                n_length = 8'd0;
            end
        end

        // Shift register steps when the timer expires
        if (i_strobe.even_tick) begin
            if (n_count == 12'd0) begin
                n_count = n_period;
                fb      = n_lfsr[0] ^ (n_short ? n_lfsr[6] : n_lfsr[1]);
                n_lfsr  = {fb, n_lfsr[14:1]};
            end else begin
                n_count = n_count - 12'd1;
            end
        end

        if (i_strobe.quarter) begin
            n_env = stng_pkg::env_clock(n_env, n_env_period, n_loop);
        end
        if (i_strobe.half && !n_loop && (n_length != 8'd0)) begin
            n_length = n_length - 8'd1;
        end
    end

    always_comb begin
        o_level = (n_enabled && (n_length != 8'd0) && !n_lfsr[0]) ?
                  (n_env_use ? n_env.vol : n_env_period) : 4'd0;
        o_length_nz = (n_length != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b0;
            r_loop       <= 1'b0;
            r_env_use    <= 1'b0;
            r_env_period <= 4'd0;
            r_env        <= '0;
            r_short      <= 1'b0;
            r_period     <= 12'd0;
            r_count      <= 12'd0;
            r_lfsr       <= 15'd1;
            r_length     <= 8'd0;
        end else begin
            r_enabled    <= n_enabled;
            r_loop       <= n_loop;
            r_env_use    <= n_env_use;
            r_env_period <= n_env_period;
            r_env        <= n_env;
            r_short      <= n_short;
            r_period     <= n_period;
            r_count      <= n_count;
            r_lfsr       <= n_lfsr;
            r_length     <= n_length;
        end
    end

endmodule
